FILE: sv/pee_pkg.sv
`timescale 1ns / 1ps

package pee_pkg;

    // field and datapath widths
    localparam int BYTE_W   = 48;
    localparam int RATE_W   = 64;
    localparam int SUM_W    = 68;   // holds 7 * rate + 3 * delta + 5
    localparam int HOURS_W  = 37;
    localparam int TIME_W   = 6;

    // constant divider: remainder width, bits per step, step counter
    localparam int CD_REM_W = 12;
    localparam int CD_DIGIT = 4;
    localparam int CD_CNT_W = 5;

    // long divider step counter
    localparam int LD_CNT_W = 6;

    localparam int STEPS_TEN  = SUM_W / CD_DIGIT;
    localparam int STEPS_HOUR = BYTE_W / CD_DIGIT;
    localparam int STEPS_MIN  = CD_REM_W / CD_DIGIT;

    localparam logic [CD_REM_W-1:0] DIV_TEN_VAL  = CD_REM_W'(10);
    localparam logic [CD_REM_W-1:0] DIV_HOUR_VAL = CD_REM_W'(3600);
    localparam logic [CD_REM_W-1:0] DIV_MIN_VAL  = CD_REM_W'(60);

    localparam logic [SUM_W-1:0] BLEND_ROUND = SUM_W'(5);

    typedef enum logic [1:0] {
        DSEL_TEN  = 2'd0,
        DSEL_HOUR = 2'd1,
        DSEL_MIN  = 2'd2
    } dsel_t;

    typedef struct packed {
        logic  start;
        dsel_t sel;
    } cdiv_req_t;

endpackage

FILE: sv/pee_cdiv.sv
`timescale 1ns / 1ps

// serial divider by a small constant, four quotient bits per cycle, msb first
module pee_cdiv
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pee_pkg::cdiv_req_t           req,
    input  logic [pee_pkg::SUM_W-1:0]    dividend,
    output logic                         done,
    output logic [pee_pkg::SUM_W-1:0]    quotient,
    output logic [pee_pkg::CD_REM_W-1:0] remainder
);

    logic [pee_pkg::SUM_W-1:0]    shift_reg;
    logic [pee_pkg::SUM_W-1:0]    shift_next;
    logic [pee_pkg::CD_REM_W-1:0] rem_reg;
    logic [pee_pkg::CD_REM_W-1:0] rem_next;
    logic [pee_pkg::CD_REM_W-1:0] div_reg;
    logic [pee_pkg::CD_REM_W-1:0] div_sel;
    logic [pee_pkg::CD_CNT_W-1:0] cnt_reg;
    logic [pee_pkg::CD_CNT_W-1:0] cnt_sel;
    logic                         busy_reg;
    logic                         done_reg;
    logic [pee_pkg::CD_REM_W:0]   part;
    logic [pee_pkg::CD_DIGIT-1:0] qbits;

    always_comb
    begin
        case (req.sel)
            pee_pkg::DSEL_TEN:
            begin
                div_sel = pee_pkg::DIV_TEN_VAL;
                cnt_sel = pee_pkg::CD_CNT_W'(pee_pkg::STEPS_TEN);
            end
            pee_pkg::DSEL_HOUR:
            begin
                div_sel = pee_pkg::DIV_HOUR_VAL;
                cnt_sel = pee_pkg::CD_CNT_W'(pee_pkg::STEPS_HOUR);
            end
            pee_pkg::DSEL_MIN:
            begin
                div_sel = pee_pkg::DIV_MIN_VAL;
                cnt_sel = pee_pkg::CD_CNT_W'(pee_pkg::STEPS_MIN);
            end
            default:
            begin
                div_sel = pee_pkg::DIV_TEN_VAL;
                cnt_sel = pee_pkg::CD_CNT_W'(pee_pkg::STEPS_TEN);
            end
        endcase
    end

    // one digit: four restoring steps on a narrow remainder
    always_comb
    begin
        rem_next = rem_reg;
        qbits    = '0;
        part     = '0;
        for (int k = 0; k < pee_pkg::CD_DIGIT; k++)
        begin
            part = {rem_next, shift_reg[pee_pkg::SUM_W-1-k]};
            if (part >= {1'b0, div_reg})
            begin
                part = part - {1'b0, div_reg};
                qbits[pee_pkg::CD_DIGIT-1-k] = 1'b1;
            end
            rem_next = part[pee_pkg::CD_REM_W-1:0];
        end
        shift_next = {shift_reg[pee_pkg::SUM_W-1-pee_pkg::CD_DIGIT:0], qbits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == pee_pkg::CD_CNT_W'(1));
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= cnt_sel;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - pee_pkg::CD_CNT_W'(1);
                if (cnt_reg == pee_pkg::CD_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= div_sel;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = shift_reg;
    assign remainder = rem_reg;

    a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("constant divider restarted while busy");

endmodule

FILE: sv/pee_ldiv.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; divisor held steady by the caller
module pee_ldiv
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pee_pkg::RATE_W-1:0] rem_init,
    input  logic [pee_pkg::BYTE_W-1:0] lo_init,
    input  logic [pee_pkg::RATE_W-1:0] divisor,
    output logic                       done,
    output logic [pee_pkg::BYTE_W-1:0] quotient
);

    logic [pee_pkg::RATE_W-1:0]   rem_reg;
    logic [pee_pkg::RATE_W-1:0]   rem_next;
    logic [pee_pkg::BYTE_W-1:0]   q_reg;
    logic [pee_pkg::LD_CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [pee_pkg::RATE_W:0]     trial;
    logic [pee_pkg::RATE_W+1:0]   diff;
    logic                         fits;

    assign trial    = {rem_reg, q_reg[pee_pkg::BYTE_W-1]};
    assign diff     = {1'b0, trial} - {2'b00, divisor};
    assign fits     = !diff[pee_pkg::RATE_W+1];
    assign rem_next = fits ? diff[pee_pkg::RATE_W-1:0] : trial[pee_pkg::RATE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == pee_pkg::LD_CNT_W'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= pee_pkg::LD_CNT_W'(pee_pkg::BYTE_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - pee_pkg::LD_CNT_W'(1);
                if (cnt_reg == pee_pkg::LD_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= rem_init;
            q_reg   <= lo_init;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= {q_reg[pee_pkg::BYTE_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < divisor))
        else $error("partial remainder not below divisor");

endmodule

FILE: sv/progress_eta_estimator.sv
// progress eta estimator: one result word for every sample word
// steps: accept, evaluate, blend the rate by ten if needed, long division of the
// remaining bytes, then split into hours, minutes and seconds by the shared divider
// a new sample word is taken only once the last result has gone to the output stage,
// which waits for the result side to take the previous result word
// asynchronous active-low reset clears the sequencer, previous sample, rate and total
`timescale 1ns / 1ps

module progress_eta_estimator
#(
    parameter int RATE_FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic [pee_pkg::BYTE_W-1:0]  cfg_wdata,
    // sample words
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [pee_pkg::BYTE_W-1:0]  done_bytes,
    // result words
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [pee_pkg::HOURS_W-1:0] eta_hours,
    output logic [pee_pkg::TIME_W-1:0]  eta_minutes,
    output logic [pee_pkg::TIME_W-1:0]  eta_seconds,
    output logic                        show_hours
);

    localparam int FIX_W = pee_pkg::BYTE_W + RATE_FRAC_BITS;

    // sequencer, one-hot
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_EVAL  = 10'b0000000010,
        S_MUL1  = 10'b0000000100,
        S_MUL2  = 10'b0000001000,
        S_BLEND = 10'b0000010000,
        S_CHECK = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_SPLIT = 10'b0010000000,
        S_HOUR  = 10'b0100000000,
        S_MIN   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    // persistent state
    logic [pee_pkg::BYTE_W-1:0]  total_reg;
    logic [pee_pkg::BYTE_W-1:0]  prev_reg, prev_next;
    logic [pee_pkg::RATE_W-1:0]  rate_reg, rate_next;

    // working registers
    logic [pee_pkg::BYTE_W-1:0]  done_reg, done_next;
    logic [pee_pkg::BYTE_W-1:0]  delta_reg, delta_next;
    logic [pee_pkg::SUM_W-1:0]   acc_reg, acc_next;
    logic [pee_pkg::SUM_W-1:0]   dsum_reg, dsum_next;
    logic [pee_pkg::BYTE_W-1:0]  eta_reg, eta_next;
    logic [pee_pkg::HOURS_W-1:0] hours_reg, hours_next;
    // minute split finished while the output stage was still full
    logic                        cd_done_seen_reg, cd_done_seen_next;

    // output stage
    logic                        out_valid_reg, out_valid_next;
    logic [pee_pkg::HOURS_W-1:0] eta_hours_reg, eta_hours_next;
    logic [pee_pkg::TIME_W-1:0]  eta_minutes_reg, eta_minutes_next;
    logic [pee_pkg::TIME_W-1:0]  eta_seconds_reg, eta_seconds_next;
    logic                        show_hours_reg, show_hours_next;
    logic                        out_free;

    // datapath helpers
    logic [pee_pkg::BYTE_W-1:0]  delta_now;
    logic [FIX_W-1:0]            seed_fix;
    logic [FIX_W-1:0]            dfix_reg;
    logic [pee_pkg::BYTE_W-1:0]  left_bytes;
    logic [FIX_W-1:0]            left_fix;

    // divider hookups
    pee_pkg::cdiv_req_t            cd_req;
    logic [pee_pkg::SUM_W-1:0]     cd_dividend;
    logic                          cd_done;
    logic [pee_pkg::SUM_W-1:0]     cd_quot;
    logic [pee_pkg::CD_REM_W-1:0]  cd_rem;
    logic                          ld_start;
    logic                          ld_done;
    logic [pee_pkg::BYTE_W-1:0]    ld_quot;

    assign delta_now  = done_reg - prev_reg;
    assign seed_fix   = {delta_now, {RATE_FRAC_BITS{1'b0}}};
    assign dfix_reg   = {delta_reg, {RATE_FRAC_BITS{1'b0}}};
    assign left_bytes = total_reg - done_reg;
    assign left_fix   = {left_bytes, {RATE_FRAC_BITS{1'b0}}};
    assign out_free   = !out_valid_reg || out_ready;

    // shared constant divider: blend by ten, then split seconds by 3600 and 60
    pee_cdiv u_cdiv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (cd_req),
        .dividend  (cd_dividend),
        .done      (cd_done),
        .quotient  (cd_quot),
        .remainder (cd_rem)
    );

    // remaining fixed-point bytes over the smoothed rate; quotient fits 48 bits
    // as the rate never falls below one whole byte per tick
    pee_ldiv u_ldiv
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ld_start),
        .rem_init (pee_pkg::RATE_W'(left_fix[FIX_W-1:pee_pkg::BYTE_W])),
        .lo_init  (left_fix[pee_pkg::BYTE_W-1:0]),
        .divisor  (rate_reg),
        .done     (ld_done),
        .quotient (ld_quot)
    );

    always_comb
    begin
        state_next        = state_reg;
        prev_next         = prev_reg;
        rate_next         = rate_reg;
        done_next         = done_reg;
        delta_next        = delta_reg;
        acc_next          = acc_reg;
        dsum_next         = dsum_reg;
        eta_next          = eta_reg;
        hours_next        = hours_reg;
        cd_done_seen_next = cd_done_seen_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        eta_hours_next    = eta_hours_reg;
        eta_minutes_next  = eta_minutes_reg;
        eta_seconds_next  = eta_seconds_reg;
        show_hours_next   = show_hours_reg;
        cd_req.start      = 1'b0;
        cd_req.sel        = pee_pkg::DSEL_TEN;
        cd_dividend       = '0;
        ld_start          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    done_next  = done_bytes;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (done_reg == '0)
                begin
                    // zero sample: state untouched, eta zero
                    eta_next   = '0;
                    state_next = S_SPLIT;
                end
                else if (prev_reg == '0)
                begin
                    // first sample only records the position
                    prev_next  = done_reg;
                    eta_next   = '0;
                    state_next = S_SPLIT;
                end
                else
                begin
                    prev_next = done_reg;
                    if (done_reg > prev_reg)
                    begin
                        delta_next = delta_now;
                        if (rate_reg == '0)
                        begin
                            rate_next  = pee_pkg::RATE_W'(seed_fix);
                            state_next = S_CHECK;
                        end
                        else
                        begin
                            state_next = S_MUL1;
                        end
                    end
                    else
                    begin
                        // stalled or backwards progress keeps the rate
                        state_next = S_CHECK;
                    end
                end
            end
            S_MUL1:
            begin
                // 7 * rate by shift and subtract, 3 * delta by shift and add
                acc_next   = pee_pkg::SUM_W'({rate_reg, 3'b000}) - pee_pkg::SUM_W'(rate_reg);
                dsum_next  = pee_pkg::SUM_W'({dfix_reg, 1'b0}) + pee_pkg::SUM_W'(dfix_reg);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                // round half up, then divide by ten serially
                cd_req.start = 1'b1;
                cd_req.sel   = pee_pkg::DSEL_TEN;
                cd_dividend  = acc_reg + dsum_reg + pee_pkg::BLEND_ROUND;
                state_next   = S_BLEND;
            end
            S_BLEND:
            begin
                if (cd_done)
                begin
                    rate_next  = cd_quot[pee_pkg::RATE_W-1:0];
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if ((rate_reg != '0) && (total_reg > done_reg))
                begin
                    ld_start   = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    // no rate yet, or job overshot: eta zero
                    eta_next   = '0;
                    state_next = S_SPLIT;
                end
            end
            S_DIV:
            begin
                if (ld_done)
                begin
                    eta_next   = ld_quot;
                    state_next = S_SPLIT;
                end
            end
            S_SPLIT:
            begin
                cd_req.start = 1'b1;
                cd_req.sel   = pee_pkg::DSEL_HOUR;
                cd_dividend  = {eta_reg, {(pee_pkg::SUM_W - pee_pkg::BYTE_W){1'b0}}};
                state_next   = S_HOUR;
            end
            S_HOUR:
            begin
                if (cd_done)
                begin
                    // hours kept, seconds within the hour go on to the minute split
                    hours_next   = cd_quot[pee_pkg::HOURS_W-1:0];
                    cd_req.start = 1'b1;
                    cd_req.sel   = pee_pkg::DSEL_MIN;
                    cd_dividend  = {cd_rem, {(pee_pkg::SUM_W - pee_pkg::CD_REM_W){1'b0}}};
                    state_next   = S_MIN;
                end
            end
            S_MIN:
            begin
                // divider results hold until the next start, so wait here for the output stage
                if ((cd_done || cd_done_seen_reg) && out_free)
                begin
                    out_valid_next    = 1'b1;
                    eta_hours_next    = hours_reg;
                    eta_minutes_next  = cd_quot[pee_pkg::TIME_W-1:0];
                    eta_seconds_next  = cd_rem[pee_pkg::TIME_W-1:0];
                    show_hours_next   = (hours_reg != '0);
                    cd_done_seen_next = 1'b0;
                    state_next        = S_IDLE;
                end
                else if (cd_done)
                begin
                    cd_done_seen_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            total_reg        <= '0;
            prev_reg         <= '0;
            rate_reg         <= '0;
            cd_done_seen_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            prev_reg         <= prev_next;
            rate_reg         <= rate_next;
            cd_done_seen_reg <= cd_done_seen_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        done_reg        <= done_next;
        delta_reg       <= delta_next;
        acc_reg         <= acc_next;
        dsum_reg        <= dsum_next;
        eta_reg         <= eta_next;
        hours_reg       <= hours_next;
        eta_hours_reg   <= eta_hours_next;
        eta_minutes_reg <= eta_minutes_next;
        eta_seconds_reg <= eta_seconds_next;
        show_hours_reg  <= show_hours_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign eta_hours   = eta_hours_reg;
    assign eta_minutes = eta_minutes_reg;
    assign eta_seconds = eta_seconds_reg;
    assign show_hours  = show_hours_reg;

    a_rate_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (rate_reg != '0) |=> (rate_reg != '0))
        else $error("smoothed rate fell back to zero");

    a_flag_matches_hours: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (show_hours_reg == (eta_hours_reg != '0)))
        else $error("hours flag disagrees with hours");

    a_time_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((eta_minutes_reg < pee_pkg::TIME_W'(60)) &&
                           (eta_seconds_reg < pee_pkg::TIME_W'(60))))
        else $error("minutes or seconds out of range");

endmodule

FILE: verif/eta_checker.sv
`timescale 1ns / 1ps

module eta_checker
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [pee_pkg::BYTE_W-1:0]  cfg_wdata,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [pee_pkg::BYTE_W-1:0]  done_bytes,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [pee_pkg::HOURS_W-1:0] eta_hours,
    input  logic [pee_pkg::TIME_W-1:0]  eta_minutes,
    input  logic [pee_pkg::TIME_W-1:0]  eta_seconds,
    input  logic                        show_hours,
    output int                          mismatches,
    output int                          words_owed
);

    localparam logic [63:0] SECS_PER_HOUR = 64'd3600;
    localparam logic [63:0] SECS_PER_MIN  = 64'd60;
    localparam logic [67:0] OLD_WEIGHT    = 68'd7;
    localparam logic [67:0] NEW_WEIGHT    = 68'd3;
    localparam logic [67:0] HALF_TENTH    = 68'd5;
    localparam logic [67:0] TENTHS        = 68'd10;

    typedef struct packed {
        logic [pee_pkg::HOURS_W-1:0] hours;
        logic [pee_pkg::TIME_W-1:0]  minutes;
        logic [pee_pkg::TIME_W-1:0]  seconds;
        logic                        show;
    } eta_t;

    eta_t                       eta_owed[$];
    logic [pee_pkg::BYTE_W-1:0] job_total;
    logic [pee_pkg::BYTE_W-1:0] last_done;
    logic [pee_pkg::RATE_W-1:0] rate;

    initial mismatches = 0;

    // 0.7 old + 0.3 new, rounded half up, kept wide so nothing overflows
    function automatic logic [pee_pkg::RATE_W-1:0] blend(
        input logic [pee_pkg::RATE_W-1:0] old,
        input logic [pee_pkg::RATE_W-1:0] fresh);
        logic [67:0] acc;
        acc = 68'(old) * OLD_WEIGHT + 68'(fresh) * NEW_WEIGHT + HALF_TENTH;
        return pee_pkg::RATE_W'(acc / TENTHS);
    endfunction

    // advances previous sample and rate, returns the split eta
    function automatic eta_t forecast_eta(input logic [pee_pkg::BYTE_W-1:0] sample);
        logic [63:0] secs;
        logic [63:0] hrs;
        logic [63:0] step;
        eta_t        res;
        secs = '0;
        if (sample != '0)
        begin
            if (last_done == '0)
                last_done = sample;
            else
            begin
                if (sample > last_done)
                begin
                    step = 64'(sample - last_done) << FRAC_BITS;
                    rate = (rate == '0) ? step : blend(rate, step);
                end
                if (rate != '0 && job_total > sample)
                    secs = (64'(job_total - sample) << FRAC_BITS) / rate;
                last_done = sample;
            end
        end
        hrs         = secs / SECS_PER_HOUR;
        res.hours   = hrs[pee_pkg::HOURS_W-1:0];
        res.minutes = pee_pkg::TIME_W'((secs / SECS_PER_MIN) % SECS_PER_MIN);
        res.seconds = pee_pkg::TIME_W'(secs % SECS_PER_MIN);
        res.show    = (hrs != '0);
        return res;
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        eta_t want;
        if (!rst_n)
        begin
            job_total = '0;
            last_done = '0;
            rate      = '0;
            eta_owed.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (eta_owed.size() == 0)
                begin
                    mismatches++;
                    $display("%0t result word with nothing owed: actual %0d h %0d m %0d s",
                             $time, eta_hours, eta_minutes, eta_seconds);
                end
                else
                begin
                    want = eta_owed.pop_front();
                    check_field("eta_hours", 64'(want.hours), 64'(eta_hours));
                    check_field("eta_minutes", 64'(want.minutes), 64'(eta_minutes));
                    check_field("eta_seconds", 64'(want.seconds), 64'(eta_seconds));
                    check_field("show_hours", 64'(want.show), 64'(show_hours));
                end
            end
            if (cfg_we)
                job_total = cfg_wdata;
            if (in_valid && in_ready)
                eta_owed.push_back(forecast_eta(done_bytes));
        end
        words_owed = eta_owed.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int          FRAC_BITS   = 16;
    localparam int          RUN_ITEMS   = 550;
    // the slowest correct run stays well within this limit
    localparam int          CYCLE_LIMIT = 1000000;
    // extra wait after the last result word before the verdict
    localparam int          DRAIN_WAIT  = 100;
    localparam logic [pee_pkg::BYTE_W-1:0] MAX_BYTES = '1;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic [pee_pkg::BYTE_W-1:0]   cfg_wdata;
    logic                         in_valid;
    logic                         in_ready;
    logic [pee_pkg::BYTE_W-1:0]   done_bytes;
    logic                         out_valid;
    logic                         out_ready;
    logic [pee_pkg::HOURS_W-1:0]  eta_hours;
    logic [pee_pkg::TIME_W-1:0]   eta_minutes;
    logic [pee_pkg::TIME_W-1:0]   eta_seconds;
    logic                         show_hours;

    int                  mismatches;
    int                  words_owed;
    int                  cycle_count;
    // idle chance per cycle in percent, for the sample and result sides
    int                  send_idle;
    int                  recv_idle;

    progress_eta_estimator #(.RATE_FRAC_BITS(FRAC_BITS)) DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .done_bytes  (done_bytes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .eta_hours   (eta_hours),
        .eta_minutes (eta_minutes),
        .eta_seconds (eta_seconds),
        .show_hours  (show_hours)
    );

    // prediction and comparison live beside the block
    eta_checker #(.FRAC_BITS(FRAC_BITS)) u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .done_bytes  (done_bytes),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .eta_hours   (eta_hours),
        .eta_minutes (eta_minutes),
        .eta_seconds (eta_seconds),
        .show_hours  (show_hours),
        .mismatches  (mismatches),
        .words_owed  (words_owed)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // result side back-pressure, drawn afresh every cycle
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle);

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic logic [pee_pkg::BYTE_W-1:0] rand_bytes();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // roughly log-uniform magnitude, up to max_w bits wide
    function automatic logic [pee_pkg::BYTE_W-1:0] rand_scaled(input int max_w);
        int w;
        w = $urandom_range(0, max_w);
        return rand_bytes() >> (pee_pkg::BYTE_W - w);
    endfunction

    // offer one sample word, with random idle cycles ahead of it
    // valid is left high on return so a back-to-back word needs no extra edge
    task automatic send_sample(input logic [pee_pkg::BYTE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        done_bytes <= value;
        do @(posedge clk); while (!in_ready);
    endtask

    // job size only changes once the block has gone quiet
    task automatic set_total(input logic [pee_pkg::BYTE_W-1:0] value);
        in_valid <= 1'b0;
        // sampled on the falling edge to keep clear of the checker's update
        do @(negedge clk); while (words_owed != 0);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [pee_pkg::BYTE_W-1:0] cur;
        logic [pee_pkg::BYTE_W-1:0] total;
        logic [pee_pkg::BYTE_W:0]   sum;
        int                         sent;
        int                         seg_len;
        int                         pick;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        in_valid    = 1'b0;
        done_bytes  = '0;
        out_ready   = 1'b0;
        cycle_count = 0;
        send_idle   = 30;
        recv_idle   = 60;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: largest job, then the special cases in turn
        set_total(MAX_BYTES);
        send_sample('0);                // zero sample before anything is known
        send_sample(48'd100);           // first sample, eta zero
        send_sample(48'd100);           // no movement and no rate yet
        send_sample(48'd50);            // backwards with no rate yet
        send_sample(48'd51);            // seeds the rate at one byte a tick
        send_sample(48'd52);            // blend of equal values, hours at the top end
        send_sample(MAX_BYTES - 1);     // huge jump
        send_sample(48'd1);             // backwards, rate kept
        send_sample(48'd2);             // small step after a huge rate
        send_sample(MAX_BYTES);         // done equals total
        send_sample('0);                // zero sample with state held

        // empty job: everything overshoots
        set_total('0);
        send_sample(48'd1000);
        send_sample(48'd5000);

        // modest job so minutes and seconds move
        set_total(48'd1000000);
        send_sample(48'd6000);
        send_sample(48'd7000);
        send_sample(48'd8000);
        send_sample(48'd8000);
        send_sample(48'd9500);
        send_sample(48'd999999);
        send_sample(48'd1000000);
        send_sample(48'd1000001);

        // random jobs: mostly rising progress with the odd stall, rewind or junk word
        cur  = 48'd1000001;
        sent = 0;
        while (sent < RUN_ITEMS)
        begin
            // idling pattern by thirds of the run
            case (sent * 3 / RUN_ITEMS)
                0:       begin send_idle = 30; recv_idle = 60; end
                1:       begin send_idle = 60; recv_idle = 30; end
                default: begin send_idle = 0;  recv_idle = 0;  end
            endcase

            pick = $urandom_range(0, 9);
            if (pick == 0)
                total = '0;
            else if (pick == 1)
                total = MAX_BYTES;
            else if (pick == 2)
                total = rand_bytes();
            else
            begin
                sum   = cur + rand_scaled(pee_pkg::BYTE_W);
                total = sum[pee_pkg::BYTE_W] ? MAX_BYTES : sum[pee_pkg::BYTE_W-1:0];
            end
            set_total(total);

            seg_len = $urandom_range(8, 40);
            repeat (seg_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // forward step; overflow wraps round into a rewind
                    sum = cur + 49'(rand_scaled(24)) + 49'd1;
                    cur = sum[pee_pkg::BYTE_W-1:0];
                end
                else if (pick < 78)
                    ;   // stalled, same count again
                else if (pick < 86)
                    cur = cur - rand_scaled(pee_pkg::BYTE_W) % (cur + 48'd1);
                else if (pick >= 92)
                    cur = rand_bytes();

                if (pick >= 86 && pick < 92)
                    send_sample('0);    // ignored word, not counted
                else
                begin
                    send_sample(cur);
                    if (cur != '0)
                        sent++;
                end
            end
        end

        in_valid <= 1'b0;
        do @(negedge clk); while (words_owed != 0);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
